// File: rtl/core/rcc_pkg.sv
// ----------------------------------------------------------------------------
// RGB / CMYK converter package
// Shared widths, constants, lane type and the restoring division step used by
// the converter pipeline.
// ----------------------------------------------------------------------------
package rcc_pkg;

    // Field widths.
    localparam int CH_W  = 8;
    localparam int PCT_W = 7;

    // Division lanes: three inks or three channels.
    localparam int NUM_LANES = 3;
    localparam int NUM_W     = 22;
    localparam int DIV_W     = 14;
    localparam int QUO_W     = 8;
    localparam int QUO_IDX_W = $clog2(QUO_W);

    // Quotient bits resolved per pipeline stage and the resulting stage count.
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QUO_W / BITS_PER_STAGE;

    // Arithmetic constants.
    localparam logic [CH_W-1:0]  CHAN_MAX = 8'd255;
    localparam logic [PCT_W-1:0] PCT_MAX  = 7'd100;
    localparam logic [DIV_W-1:0] CMYK_DIV = 14'd10000;

    // Black percent is (255 - max) * 100 / 255, done as a multiply by
    // 100 * ceil(2^23 / 255) and a shift by 23. The error stays below 1/255
    // for every 8-bit input, so the truncated quotient is exact.
    localparam int                      BLACK_PROD_W = 30;
    localparam int                      BLACK_SHIFT  = 23;
    localparam logic [BLACK_PROD_W-1:0] BLACK_RECIP  = 30'd3289700;

    // Conversion direction.
    typedef enum logic {
        MODE_RGB2CMYK = 1'b0,
        MODE_CMYK2RGB = 1'b1
    } mode_t;

    // One division lane: running remainder, partial quotient and divisor.
    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [DIV_W-1:0] dvs;
    } lane_t;

    // Clamp a percent input to 100.
    function automatic logic [PCT_W-1:0] sat_pct(logic [PCT_W-1:0] v);
        return (v > PCT_MAX) ? PCT_MAX : v;
    endfunction

    // One restoring division step for quotient bit bit_pos.
    function automatic lane_t div_step(lane_t x, logic [QUO_IDX_W-1:0] bit_pos);
        logic [NUM_W-1:0] sh;
        lane_t            y;
        y  = x;
        sh = {{(NUM_W-DIV_W){1'b0}}, x.dvs} << bit_pos;
        if (x.rem >= sh)
        begin
            y.rem          = x.rem - sh;
            y.quo[bit_pos] = 1'b1;
        end
        return y;
    endfunction

endpackage

// File: rtl/core/rgb_cmyk_color_converter.sv
// ----------------------------------------------------------------------------
// RGB / CMYK color converter
// Fully pipelined converter: operand preparation, numerator scaling and a
// four-stage restoring divider shared by both directions.
// ----------------------------------------------------------------------------
// A transaction accepted at a clock edge passes through the prepare, scale,
// divider and output registers before the result ports show it with done high.
// Throughput: one transaction per clock while busy is low; the seven register
// stages (prepare, scale, four divider stages of two quotient bits each,
// output) all advance every cycle, and the receiver cannot stall the pipeline.
// Reset: rst_n clears all valid bits and holds busy high until the first edge
// after release.
module rgb_cmyk_color_converter (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      mode,
    input  logic [rcc_pkg::CH_W-1:0]  red_in,
    input  logic [rcc_pkg::CH_W-1:0]  green_in,
    input  logic [rcc_pkg::CH_W-1:0]  blue_in,
    input  logic [rcc_pkg::PCT_W-1:0] cyan_in,
    input  logic [rcc_pkg::PCT_W-1:0] magenta_in,
    input  logic [rcc_pkg::PCT_W-1:0] yellow_in,
    input  logic [rcc_pkg::PCT_W-1:0] black_in,
    output logic                      done,
    output logic [rcc_pkg::CH_W-1:0]  red_out,
    output logic [rcc_pkg::CH_W-1:0]  green_out,
    output logic [rcc_pkg::CH_W-1:0]  blue_out,
    output logic [rcc_pkg::PCT_W-1:0] cyan_out,
    output logic [rcc_pkg::PCT_W-1:0] magenta_out,
    output logic [rcc_pkg::PCT_W-1:0] yellow_out,
    output logic [rcc_pkg::PCT_W-1:0] black_out
);
    import rcc_pkg::*;

    localparam int LATENCY = DIV_STAGES + 3;

    logic busy_reg;
    logic accept;

    // Stage 1: operands and divisors.
    logic              s1_valid_reg;
    mode_t             s1_mode_reg;
    logic [DIV_W-1:0]  s1_a_reg    [NUM_LANES];
    logic [DIV_W-1:0]  s1_a_next   [NUM_LANES];
    logic [DIV_W-1:0]  s1_d_reg    [NUM_LANES];
    logic [DIV_W-1:0]  s1_d_next   [NUM_LANES];
    logic [CH_W-1:0]   s1_kd_reg;
    logic [CH_W-1:0]   s1_kd_next;
    logic [CH_W-1:0]   mx;
    logic [CH_W-1:0]   mx_div;
    logic [PCT_W-1:0]  c_inv;
    logic [PCT_W-1:0]  m_inv;
    logic [PCT_W-1:0]  y_inv;
    logic [PCT_W-1:0]  k_inv;

    // Divider pipeline; entry 0 is the scaled numerator stage.
    logic              st_valid_reg [DIV_STAGES+1];
    mode_t             st_mode_reg  [DIV_STAGES+1];
    lane_t             st_reg       [DIV_STAGES+1][NUM_LANES];
    lane_t             st0_next     [NUM_LANES];

    // Black percent travels beside the divider lanes.
    logic [PCT_W-1:0]        st_black_reg [DIV_STAGES+1];
    logic [PCT_W-1:0]        st_black_next;
    logic [BLACK_PROD_W-1:0] black_prod;

    // Output register.
    logic              done_reg;
    logic [CH_W-1:0]   red_reg,  red_next;
    logic [CH_W-1:0]   green_reg, green_next;
    logic [CH_W-1:0]   blue_reg, blue_next;
    logic [PCT_W-1:0]  cyan_reg, cyan_next;
    logic [PCT_W-1:0]  magenta_reg, magenta_next;
    logic [PCT_W-1:0]  yellow_reg, yellow_next;
    logic [PCT_W-1:0]  black_reg, black_next;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    // Busy is held only through reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b1;
        else
            busy_reg <= 1'b0;
    end

    // Stage 1 logic: channel maximum, differences or ink complements.
    always_comb
    begin
        mx = red_in;
        if (green_in > mx)
            mx = green_in;
        if (blue_in > mx)
            mx = blue_in;
        mx_div     = (mx == '0) ? CH_W'(1) : mx;
        s1_kd_next = CHAN_MAX - mx;
        c_inv      = PCT_MAX - sat_pct(cyan_in);
        m_inv      = PCT_MAX - sat_pct(magenta_in);
        y_inv      = PCT_MAX - sat_pct(yellow_in);
        k_inv      = PCT_MAX - sat_pct(black_in);
        if (mode_t'(mode) == MODE_RGB2CMYK)
        begin
            s1_a_next[0] = DIV_W'(mx - red_in);
            s1_a_next[1] = DIV_W'(mx - green_in);
            s1_a_next[2] = DIV_W'(mx - blue_in);
            for (int i = 0; i < NUM_LANES; i++)
                s1_d_next[i] = DIV_W'(mx_div);
        end
        else
        begin
            s1_a_next[0] = DIV_W'(c_inv) * DIV_W'(k_inv);
            s1_a_next[1] = DIV_W'(m_inv) * DIV_W'(k_inv);
            s1_a_next[2] = DIV_W'(y_inv) * DIV_W'(k_inv);
            for (int i = 0; i < NUM_LANES; i++)
                s1_d_next[i] = CMYK_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        s1_mode_reg <= mode_t'(mode);
        s1_a_reg    <= s1_a_next;
        s1_d_reg    <= s1_d_next;
        s1_kd_reg   <= s1_kd_next;
    end

    // Stage 2 logic: scale by 100 for inks or by 255 for channels, and derive
    // black from the headroom above the channel maximum.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            st0_next[i].quo = '0;
            st0_next[i].dvs = s1_d_reg[i];
            if (s1_mode_reg == MODE_RGB2CMYK)
                st0_next[i].rem = (NUM_W'(s1_a_reg[i]) << 6) + (NUM_W'(s1_a_reg[i]) << 5)
                                + (NUM_W'(s1_a_reg[i]) << 2);
            else
                st0_next[i].rem = (NUM_W'(s1_a_reg[i]) << 8) - NUM_W'(s1_a_reg[i]);
        end
        black_prod    = BLACK_PROD_W'(s1_kd_reg) * BLACK_RECIP;
        st_black_next = black_prod[BLACK_SHIFT +: PCT_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg[0] <= 1'b0;
        else
            st_valid_reg[0] <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        st_mode_reg[0]  <= s1_mode_reg;
        st_reg[0]       <= st0_next;
        st_black_reg[0] <= st_black_next;
    end

    // Divider stages, most significant quotient bits first.
    for (genvar g = 1; g <= DIV_STAGES; g++)
    begin : g_div
        localparam int HI = QUO_W - BITS_PER_STAGE * (g - 1) - 1;
        lane_t lane_next [NUM_LANES];

        always_comb
        begin
            for (int i = 0; i < NUM_LANES; i++)
            begin
                lane_next[i] = st_reg[g-1][i];
                for (int b = 0; b < BITS_PER_STAGE; b++)
                    lane_next[i] = div_step(lane_next[i], QUO_IDX_W'(HI - b));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                st_valid_reg[g] <= 1'b0;
            else
                st_valid_reg[g] <= st_valid_reg[g-1];
        end

        always_ff @(posedge clk)
        begin
            st_mode_reg[g]  <= st_mode_reg[g-1];
            st_reg[g]       <= lane_next;
            st_black_reg[g] <= st_black_reg[g-1];
        end
    end

    // Output selection: the unused direction reads as zero.
    always_comb
    begin
        red_next     = '0;
        green_next   = '0;
        blue_next    = '0;
        cyan_next    = '0;
        magenta_next = '0;
        yellow_next  = '0;
        black_next   = '0;
        if (st_mode_reg[DIV_STAGES] == MODE_RGB2CMYK)
        begin
            cyan_next    = st_reg[DIV_STAGES][0].quo[PCT_W-1:0];
            magenta_next = st_reg[DIV_STAGES][1].quo[PCT_W-1:0];
            yellow_next  = st_reg[DIV_STAGES][2].quo[PCT_W-1:0];
            black_next   = st_black_reg[DIV_STAGES];
        end
        else
        begin
            red_next   = st_reg[DIV_STAGES][0].quo[CH_W-1:0];
            green_next = st_reg[DIV_STAGES][1].quo[CH_W-1:0];
            blue_next  = st_reg[DIV_STAGES][2].quo[CH_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= st_valid_reg[DIV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        red_reg     <= red_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
        cyan_reg    <= cyan_next;
        magenta_reg <= magenta_next;
        yellow_reg  <= yellow_next;
        black_reg   <= black_next;
    end

    assign done        = done_reg;
    assign red_out     = red_reg;
    assign green_out   = green_reg;
    assign blue_out    = blue_reg;
    assign cyan_out    = cyan_reg;
    assign magenta_out = magenta_reg;
    assign yellow_out  = yellow_reg;
    assign black_out   = black_reg;

    // Every result traces back to an earlier start request.
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result without a matching transaction");

    // Percent results never exceed 100.
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cyan_out <= PCT_MAX) && (magenta_out <= PCT_MAX)
              && (yellow_out <= PCT_MAX) && (black_out <= PCT_MAX))
        else $error("percent result above 100");

    // In RGB to CMYK direction the channel results are zero.
    a_rgb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(mode, LATENCY) == MODE_RGB2CMYK)
            |-> (red_out == '0) && (green_out == '0) && (blue_out == '0))
        else $error("channel results not cleared in RGB to CMYK direction");

    // In CMYK to RGB direction the percent results are zero.
    a_cmyk_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && ($past(mode, LATENCY) == MODE_CMYK2RGB)
            |-> (cyan_out == '0) && (magenta_out == '0)
             && (yellow_out == '0) && (black_out == '0))
        else $error("percent results not cleared in CMYK to RGB direction");

    // Pure black input gives full black ink.
    a_black_input: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past((mode == MODE_RGB2CMYK) && (red_in == '0) && (green_in == '0)
                      && (blue_in == '0), LATENCY)
            |-> (black_out == PCT_MAX) && (cyan_out == '0))
        else $error("black input did not convert to full black");

endmodule
